// ===== rtl/mtns_pkg.sv =====
// Shared types and constants for the mass tolerance nearest search block.
`default_nettype none

package mtns_pkg;

    localparam int MASS_W = 40;
    localparam int ERR_W  = 24;
    localparam int CFG_W  = 24;

    localparam logic [CFG_W-1:0] WATER_OFFSET_RESET = 24'd1180640;
    localparam logic [CFG_W-1:0] TOLERANCE_RESET    = 24'd65536;

    localparam logic CFG_WATER_OFFSET = 1'b0;
    localparam logic CFG_TOLERANCE    = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PEVAL,
        ST_PDEC,
        ST_FEVAL,
        ST_FDEC,
        ST_DOWN,
        ST_DN_EVAL,
        ST_DN_DEC,
        ST_UP,
        ST_UP_EVAL,
        ST_UP_DEC,
        ST_UP_NEXT,
        ST_RESULT,
        ST_MISS
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_APPEND,
        DP_START,
        DP_RD_MID,
        DP_RD_LO,
        DP_RD_DEC,
        DP_RD_POS_UP,
        DP_RD_INC,
        DP_EVAL,
        DP_HIT,
        DP_GO_HI,
        DP_GO_LO,
        DP_BEST,
        DP_OUT_HIT,
        DP_OUT_MISS
    } dp_op_t;

    typedef struct packed {
        logic count_zero;
        logic lo_lt_hi;
        logic hit;
        logic above;
        logic addr_zero;
        logic pos_top;
        logic addr_top;
        logic out_free;
        logic overflow;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mtns_ctrl.sv =====
// Controller state machine that sequences the search, the scan and the result.
`default_nettype none

module mtns_ctrl
    import mtns_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic [1:0]          s_opcode,
    output logic                     s_ready,
    input  wire dp_stat_t            stat,
    output dp_op_t                   dp_op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (opcode_t'(s_opcode) == OP_QUERY)) begin
                    state_next = stat.count_zero ? ST_MISS : ST_PROBE;
                end
            end
            ST_PROBE:   state_next = stat.lo_lt_hi ? ST_PEVAL : ST_FEVAL;
            ST_PEVAL:   state_next = ST_PDEC;
            ST_PDEC:    state_next = stat.hit ? ST_DOWN : ST_PROBE;
            ST_FEVAL:   state_next = ST_FDEC;
            ST_FDEC:    state_next = stat.hit ? ST_DOWN : ST_MISS;
            ST_DOWN:    state_next = stat.addr_zero ? ST_UP : ST_DN_EVAL;
            ST_DN_EVAL: state_next = ST_DN_DEC;
            ST_DN_DEC:  state_next = stat.hit ? ST_DOWN : ST_UP;
            ST_UP:      state_next = stat.pos_top ? ST_RESULT : ST_UP_EVAL;
            ST_UP_EVAL: state_next = ST_UP_DEC;
            ST_UP_DEC:  state_next = stat.hit ? ST_UP_NEXT : ST_RESULT;
            ST_UP_NEXT: state_next = stat.addr_top ? ST_RESULT : ST_UP_EVAL;
            ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        dp_op   = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (opcode_t'(s_opcode))
                        OP_CLEAR:  dp_op = DP_CLEAR;
                        OP_APPEND: dp_op = DP_APPEND;
                        OP_QUERY:  dp_op = DP_START;
                        default:   dp_op = DP_NOP;
                    endcase
                end
            end
            ST_PROBE:   dp_op = stat.lo_lt_hi ? DP_RD_MID : DP_RD_LO;
            ST_PEVAL:   dp_op = DP_EVAL;
            ST_PDEC: begin
                priority if (stat.hit) begin
                    dp_op = DP_HIT;
                end else if (stat.above) begin
                    dp_op = DP_GO_HI;
                end else begin
                    dp_op = DP_GO_LO;
                end
            end
            ST_FEVAL:   dp_op = DP_EVAL;
            ST_FDEC:    dp_op = stat.hit ? DP_HIT : DP_NOP;
            ST_DOWN:    dp_op = stat.addr_zero ? DP_NOP : DP_RD_DEC;
            ST_DN_EVAL: dp_op = DP_EVAL;
            ST_DN_DEC:  dp_op = stat.hit ? DP_BEST : DP_NOP;
            ST_UP:      dp_op = stat.pos_top ? DP_NOP : DP_RD_POS_UP;
            ST_UP_EVAL: dp_op = DP_EVAL;
            ST_UP_DEC:  dp_op = stat.hit ? DP_BEST : DP_NOP;
            ST_UP_NEXT: dp_op = stat.addr_top ? DP_NOP : DP_RD_INC;
            ST_RESULT:  dp_op = stat.out_free ? DP_OUT_HIT : DP_NOP;
            ST_MISS:    dp_op = stat.out_free ? DP_OUT_MISS : DP_NOP;
            default:    dp_op = DP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mtns_dp.sv =====
// Datapath with the mass table, search bounds, error unit and output register.
`default_nettype none

module mtns_dp
    import mtns_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_op_t            dp_op,
    output dp_stat_t               stat,
    input  wire logic [MASS_W-1:0] s_mass_value,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_match_found,
    output logic [ERR_W-1:0]       m_min_error,
    output logic                   m_table_overflow
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = MASS_W + 1;

    logic [MASS_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]     count_reg;
    logic              overflow_reg;
    logic [CFG_W-1:0]  water_reg;
    logic [CFG_W-1:0]  tol_reg;
    logic              m_valid_reg;

    logic [MASS_W-1:0] query_reg;
    logic [MASS_W-1:0] rd_data_reg;
    logic [IW-1:0]     lo_reg;
    logic [IW-1:0]     hi_reg;
    logic [IW-1:0]     addr_reg;
    logic [IW-1:0]     addr_next;
    logic [IW-1:0]     pos_reg;
    logic [ERR_W-1:0]  best_reg;
    logic [ERR_W-1:0]  err_reg;
    logic              within_reg;
    logic              above_reg;
    logic              m_match_found_reg;
    logic [ERR_W-1:0]  m_min_error_reg;
    logic              m_table_overflow_reg;

    logic              full;
    logic              rd_en;
    logic [IW:0]       mid_sum;
    logic [SW-1:0]     sum;
    logic [SW-1:0]     query_ext;
    logic              above;
    logic [SW-1:0]     err_full;
    logic              in_tol;
    logic              out_load;

    assign full     = (count_reg == CW'(TABLE_DEPTH));
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign out_load = (dp_op == DP_OUT_HIT) || (dp_op == DP_OUT_MISS);

    always_comb begin
        addr_next = addr_reg;
        rd_en     = 1'b1;
        unique case (dp_op)
            DP_RD_MID:    addr_next = mid_sum[IW:1];
            DP_RD_LO:     addr_next = lo_reg;
            DP_RD_DEC:    addr_next = addr_reg - IW'(1);
            DP_RD_POS_UP: addr_next = pos_reg + IW'(1);
            DP_RD_INC:    addr_next = addr_reg + IW'(1);
            default:      rd_en     = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if ((dp_op == DP_APPEND) && !full) begin
            mem[count_reg[IW-1:0]] <= s_mass_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr_next];
        end
    end

    assign sum       = {1'b0, rd_data_reg} + SW'(water_reg);
    assign query_ext = {1'b0, query_reg};
    assign above     = (sum > query_ext);
    assign err_full  = above ? (sum - query_ext) : (query_ext - sum);
    assign in_tol    = (err_full < SW'(tol_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            water_reg    <= WATER_OFFSET_RESET;
            tol_reg      <= TOLERANCE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_WATER_OFFSET: water_reg <= cfg_wr_data;
                    CFG_TOLERANCE:    tol_reg   <= cfg_wr_data;
                    default:          water_reg <= water_reg;
                endcase
            end
            if (dp_op == DP_CLEAR) begin
                count_reg <= '0;
            end else if (dp_op == DP_APPEND) begin
                if (full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (dp_op)
            DP_START: begin
                query_reg <= s_mass_value;
                lo_reg    <= '0;
                hi_reg    <= IW'(count_reg - CW'(1));
            end
            DP_RD_MID, DP_RD_LO, DP_RD_DEC, DP_RD_POS_UP, DP_RD_INC: begin
                addr_reg <= addr_next;
            end
            DP_EVAL: begin
                err_reg    <= err_full[ERR_W-1:0];
                within_reg <= in_tol;
                above_reg  <= above;
            end
            DP_HIT: begin
                pos_reg  <= addr_reg;
                best_reg <= err_reg;
            end
            DP_GO_HI: hi_reg <= addr_reg;
            DP_GO_LO: lo_reg <= addr_reg + IW'(1);
            DP_BEST: begin
                if (err_reg < best_reg) begin
                    best_reg <= err_reg;
                end
            end
            DP_OUT_HIT: begin
                m_match_found_reg    <= 1'b1;
                m_min_error_reg      <= best_reg;
                m_table_overflow_reg <= overflow_reg;
            end
            DP_OUT_MISS: begin
                m_match_found_reg    <= 1'b0;
                m_min_error_reg      <= '0;
                m_table_overflow_reg <= overflow_reg;
            end
            default: begin
                best_reg <= best_reg;
            end
        endcase
    end

    always_comb begin
        stat.count_zero = (count_reg == '0);
        stat.lo_lt_hi   = (lo_reg < hi_reg);
        stat.hit        = within_reg;
        stat.above      = above_reg;
        stat.addr_zero  = (addr_reg == '0);
        stat.pos_top    = ((CW'(pos_reg) + CW'(1)) >= count_reg);
        stat.addr_top   = ((CW'(addr_reg) + CW'(1)) >= count_reg);
        stat.out_free   = !m_valid_reg || m_ready;
        stat.overflow   = overflow_reg;
    end

    assign m_valid          = m_valid_reg;
    assign m_match_found    = m_match_found_reg;
    assign m_min_error      = m_min_error_reg;
    assign m_table_overflow = m_table_overflow_reg;

endmodule

`default_nettype wire

// ===== rtl/mass_tolerance_nearest_search.sv =====
// Top level of the mass tolerance nearest search block.
// The input channel (s_valid, s_ready, s_opcode, s_mass_value) carries one word per
// command: clear the table, append one mass, or query with a precursor mass.
// Only a query produces a result word on the m_ channel, holding the match flag,
// the smallest absolute error and the sticky table overflow flag.
// After a clear or an append, s_ready stays high for the next word.
// A query runs a binary search over the table and then scans the tolerance window
// both ways; every table read goes through a read, an error compute and a decision
// step through the single memory read port. With an empty table the query goes
// straight to the miss state, whose result waits for a free output register.
// s_ready is low while a query runs, and the block takes one item at a time.
// The result sits in an output register, so the next word is accepted while an
// earlier result waits; if the receiver stalls, a finished query waits until
// the output register frees up before the block returns to idle.
// Reset empties the table, clears the overflow flag and restores the water offset
// and tolerance registers; the table memory itself is not cleared.
// Configuration writes on cfg_wr_en take effect at once and belong to idle time.
`default_nettype none

module mass_tolerance_nearest_search
    import mtns_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [MASS_W-1:0] s_mass_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_match_found,
    output logic [ERR_W-1:0]       m_min_error,
    output logic                   m_table_overflow,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data
);

    dp_stat_t stat;
    dp_op_t   dp_op;

    mtns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .stat     (stat),
        .dp_op    (dp_op)
    );

    mtns_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dp_op            (dp_op),
        .stat             (stat),
        .s_mass_value     (s_mass_value),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_found    (m_match_found),
        .m_min_error      (m_min_error),
        .m_table_overflow (m_table_overflow)
    );

    a_miss_zero_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_match_found) |-> (m_min_error == '0))
        else $error("no-match result carries a nonzero error");

    a_ready_only_idle_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (dp_op == DP_NOP || dp_op == DP_CLEAR || dp_op == DP_APPEND
                     || dp_op == DP_START))
        else $error("search operation issued while accepting a word");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.overflow |=> stat.overflow)
        else $error("overflow flag dropped without reset");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_op == DP_OUT_HIT || dp_op == DP_OUT_MISS) |-> (!m_valid || m_ready))
        else $error("result loaded over a word that was not taken");

endmodule

`default_nettype wire

// ===== test/mass_tolerance_nearest_search_checker.sv =====
// Checker that predicts and compares the result words of the mass tolerance search block.
`timescale 1ns / 1ps
`default_nettype none

module mass_tolerance_nearest_search_checker
    import mtns_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [MASS_W-1:0] s_mass_value,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic              m_match_found,
    input  wire logic [ERR_W-1:0]  m_min_error,
    input  wire logic              m_table_overflow,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic             hit;
        logic [ERR_W-1:0] err;
        logic             ovf;
    } search_result_t;

    search_result_t    expected_results[$];
    logic [MASS_W-1:0] mass_mem [TABLE_DEPTH];
    int unsigned       n_entries;
    logic              ovf_flag;
    logic [CFG_W-1:0]  water;
    logic [CFG_W-1:0]  tol;

    function automatic logic [MASS_W:0] mass_error(input logic [MASS_W-1:0] entry,
                                                   input logic [MASS_W-1:0] query);
        logic [MASS_W:0] shifted;
        logic [MASS_W:0] q;
        shifted = {1'b0, entry} + {{(MASS_W+1-CFG_W){1'b0}}, water};
        q = {1'b0, query};
        return (shifted >= q) ? shifted - q : q - shifted;
    endfunction

    function automatic logic in_window(input logic [MASS_W-1:0] entry,
                                       input logic [MASS_W-1:0] query);
        return mass_error(entry, query) < {{(MASS_W+1-CFG_W){1'b0}}, tol};
    endfunction

    function automatic search_result_t nearest_match(input logic [MASS_W-1:0] query);
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        int unsigned     pos;
        int unsigned     i;
        logic            hit;
        logic [MASS_W:0] best;
        logic [MASS_W:0] e;
        search_result_t  r;
        hit = 1'b0;
        pos = 0;
        lo = 0;
        best = '0;
        if (n_entries > 0) begin
            hi = n_entries - 1;
            while (lo < hi && !hit) begin
                mid = (lo + hi) / 2;
                if (in_window(mass_mem[mid], query)) begin
                    pos = mid;
                    hit = 1'b1;
                end else if ({1'b0, mass_mem[mid]} + {{(MASS_W+1-CFG_W){1'b0}}, water}
                             > {1'b0, query}) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            if (!hit && lo < n_entries && in_window(mass_mem[lo], query)) begin
                pos = lo;
                hit = 1'b1;
            end
        end
        if (hit) begin
            best = mass_error(mass_mem[pos], query);
            i = pos;
            while (i > 0) begin
                i--;
                if (!in_window(mass_mem[i], query))
                    break;
                e = mass_error(mass_mem[i], query);
                if (e < best)
                    best = e;
            end
            for (i = pos + 1; i < n_entries; i++) begin
                if (!in_window(mass_mem[i], query))
                    break;
                e = mass_error(mass_mem[i], query);
                if (e < best)
                    best = e;
            end
        end
        r.hit = hit;
        r.err = hit ? best[ERR_W-1:0] : '0;
        r.ovf = ovf_flag;
        return r;
    endfunction

    always @(posedge aclk) begin
        search_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            n_entries = 0;
            ovf_flag = 1'b0;
            water = WATER_OFFSET_RESET;
            tol = TOLERANCE_RESET;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no query waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_match_found !== want.hit) begin
                        $error("match_found expected %0d actual %0d", want.hit, m_match_found);
                        fail_count++;
                    end
                    if (m_min_error !== want.err) begin
                        $error("min_error expected %0d actual %0d", want.err, m_min_error);
                        fail_count++;
                    end
                    if (m_table_overflow !== want.ovf) begin
                        $error("table_overflow expected %0d actual %0d",
                               want.ovf, m_table_overflow);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_WATER_OFFSET)
                    water = cfg_wr_data;
                else
                    tol = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                case (s_opcode)
                    OP_CLEAR: n_entries = 0;
                    OP_APPEND: begin
                        if (n_entries < TABLE_DEPTH) begin
                            mass_mem[n_entries] = s_mass_value;
                            n_entries++;
                        end else begin
                            ovf_flag = 1'b1;
                        end
                    end
                    OP_QUERY: expected_results = {expected_results,
                                                  nearest_match(s_mass_value)};
                    default: ;
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

// ===== test/tb_mass_tolerance_nearest_search.sv =====
// Testbench top for the mass tolerance nearest search block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_mass_tolerance_nearest_search;
    import mtns_pkg::*;

    localparam int         DEPTH       = 4096;
    localparam logic [1:0] OPC_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 50000;
    localparam int         HOLD_CYCLES = 400;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_opcode;
    logic [MASS_W-1:0] s_mass_value;
    logic              m_valid;
    logic              m_ready;
    logic              m_match_found;
    logic [ERR_W-1:0]  m_min_error;
    logic              m_table_overflow;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_wr_data;
    int                fail_count;
    int                pending;

    int                idle_cycles;
    int                burst_left;
    int                items_sent;
    int                table_fill;
    int                hold_req;
    int                hold_done;
    int                ready_mode;
    int                mode_left;
    logic [CFG_W-1:0]  cur_water;
    logic [CFG_W-1:0]  cur_tol;
    logic [MASS_W-1:0] loaded[$];

    mass_tolerance_nearest_search #(.TABLE_DEPTH(DEPTH)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_mass_value(s_mass_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_match_found(m_match_found),
        .m_min_error(m_min_error),
        .m_table_overflow(m_table_overflow),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    mass_tolerance_nearest_search_checker #(.TABLE_DEPTH(DEPTH)) u_search_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_mass_value(s_mass_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_match_found(m_match_found),
        .m_min_error(m_min_error),
        .m_table_overflow(m_table_overflow),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("mass_tolerance_nearest_search: mismatch");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        hold_done = 0;
        ready_mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = hold_req;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (ready_mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [MASS_W-1:0] rand_mass();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MASS_W-1:0];
    endfunction

    // Query mass placed around a loaded entry, at the window edges or inside it.
    function automatic logic [MASS_W-1:0] near_entry_mass();
        longint      q;
        longint      d;
        logic [63:0] qv;
        case ($urandom_range(0, 5))
            0: d = 0;
            1: d = longint'(cur_tol) - 1;
            2: d = 1 - longint'(cur_tol);
            3: d = longint'(cur_tol);
            4: d = -longint'(cur_tol);
            default: d = longint'($urandom_range(0, 2 * cur_tol)) - longint'(cur_tol);
        endcase
        q = longint'({24'd0, loaded[$urandom_range(0, loaded.size() - 1)]})
            + longint'(cur_water) + d;
        qv = q;
        return qv[MASS_W-1:0];
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [MASS_W-1:0] mass);
        s_valid = 1'b1;
        s_opcode = op;
        s_mass_value = mass;
        do @(posedge aclk); while (!s_ready);
        if (op != OPC_UNUSED)
            items_sent++;
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(20, 60)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic do_clear(input logic [MASS_W-1:0] mass);
        send_word(OP_CLEAR, mass);
        table_fill = 0;
        loaded.delete();
    endtask

    task automatic do_append(input logic [MASS_W-1:0] mass);
        send_word(OP_APPEND, mass);
        if (table_fill < DEPTH)
            loaded = {loaded, mass};
        table_fill++;
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_WATER_OFFSET)
            cur_water = data;
        else
            cur_tol = data;
    endtask

    task automatic random_queries(input int count);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                6: send_word(OP_QUERY, rand_mass());
                7: send_word(OP_QUERY, '0);
                8: send_word(OP_QUERY, '1);
                9: send_word(OPC_UNUSED, rand_mass());
                default: begin
                    if (loaded.size() > 0)
                        send_word(OP_QUERY, near_entry_mass());
                    else
                        send_word(OP_QUERY, rand_mass());
                end
            endcase
        end
    endtask

    task automatic run_segment(input bit force_cfg);
        int          n;
        bit          sorted;
        longint      stride_max;
        logic [63:0] base;
        logic [CFG_W-1:0] v;
        if (force_cfg || $urandom_range(0, 2) == 0) begin
            wait_idle();
            if (force_cfg || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = '1;
                    2: v = WATER_OFFSET_RESET;
                    default: v = CFG_W'($urandom);
                endcase
                write_cfg(CFG_WATER_OFFSET, v);
            end
            if (force_cfg || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 6))
                    0: v = '0;
                    1: v = 24'd1;
                    2: v = '1;
                    3: v = TOLERANCE_RESET;
                    4: v = CFG_W'($urandom_range(2, 4096));
                    default: v = CFG_W'($urandom_range(1, 1 << 20));
                endcase
                write_cfg(CFG_TOLERANCE, v);
            end
        end
        if (table_fill >= 3000 || $urandom_range(0, 5) != 0)
            do_clear(rand_mass());
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        sorted = ($urandom_range(0, 7) != 0);
        stride_max = 2 * longint'(cur_tol) + 1;
        base = {24'd0, rand_mass()} >> $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
            if (sorted)
                do_append(base[MASS_W-1:0]);
            else
                do_append(rand_mass());
            base = base + longint'($urandom_range(0, 32'(stride_max)));
            if ($urandom_range(0, 19) == 0)
                send_word(OPC_UNUSED, rand_mass());
        end
        random_queries($urandom_range(1, 10));
    endtask

    task automatic long_hold();
        wait_idle();
        hold_req++;
        if (loaded.size() > 0)
            for (int k = 0; k < 8; k++) send_word(OP_QUERY, near_entry_mass());
        else
            for (int k = 0; k < 8; k++) send_word(OP_QUERY, rand_mass());
        wait_idle();
    endtask

    initial begin
        int          target;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_CLEAR;
        s_mass_value = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_WATER_OFFSET;
        cfg_wr_data = '0;
        cur_water = WATER_OFFSET_RESET;
        cur_tol = TOLERANCE_RESET;
        burst_left = 1;
        items_sent = 0;
        table_fill = 0;
        hold_req = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_word(OP_QUERY, 40'd0);
        send_word(OPC_UNUSED, '1);
        do_append(40'd0);
        do_append(40'd1000000);
        do_append('1);
        send_word(OP_QUERY, MASS_W'(WATER_OFFSET_RESET));
        send_word(OP_QUERY, 40'd1000000 + WATER_OFFSET_RESET + 40'd65535);
        send_word(OP_QUERY, 40'd1000000 + WATER_OFFSET_RESET - 40'd65536);
        send_word(OP_QUERY, '1);
        send_word(OP_QUERY, 40'd0);
        do_clear('1);
        send_word(OP_QUERY, MASS_W'(WATER_OFFSET_RESET));
        for (int k = 1; k <= 5; k++) do_append(40'(100 * k));
        send_word(OP_QUERY, 40'd300 + WATER_OFFSET_RESET);
        send_word(OP_QUERY, 40'd150 + WATER_OFFSET_RESET);
        send_word(OP_QUERY, 40'd500 + WATER_OFFSET_RESET + 40'd65535);

        run_segment(1'b1);
        while (items_sent < 500) run_segment(1'b0);
        long_hold();

        target = items_sent + 500;
        long_hold();
        while (items_sent < target) run_segment(1'b0);

        wait_idle();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("mass_tolerance_nearest_search: match");
        else
            $display("mass_tolerance_nearest_search: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
